### hdl/sdspi_pkg.sv
// sdspi_pkg: shared types, phase and return codes for the spi-mode sd host engine
// no dependencies
package sdspi_pkg;

   localparam int BlockBytes = 512;

   // input actions
   localparam logic [2:0] ACT_INIT  = 3'd0;
   localparam logic [2:0] ACT_READ  = 3'd1;
   localparam logic [2:0] ACT_WRITE = 3'd2;
   localparam logic [2:0] ACT_XCHG  = 3'd3;
   localparam logic [2:0] ACT_DATA  = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NRDY    = 3'd1;
   localparam logic [2:0] ST_CMDERR  = 3'd2;
   localparam logic [2:0] ST_TOKTO   = 3'd3;
   localparam logic [2:0] ST_WREJ    = 3'd4;
   localparam logic [2:0] ST_NOCARD  = 3'd5;
   localparam logic [2:0] ST_BADCARD = 3'd6;

   // card kinds
   localparam logic [2:0] CK_NONE = 3'd0;
   localparam logic [2:0] CK_MMC  = 3'd1;
   localparam logic [2:0] CK_SDV1 = 3'd2;
   localparam logic [2:0] CK_SDV2 = 3'd3;
   localparam logic [2:0] CK_SDHC = 3'd4;
   localparam logic [2:0] CK_ERR  = 3'd5;

   // configuration register indexes
   localparam logic [2:0] REG_READY_WAIT = 3'd0;
   localparam logic [2:0] REG_TOKEN_WAIT = 3'd1;
   localparam logic [2:0] REG_INIT_POLL  = 3'd2;
   localparam logic [2:0] REG_IDLE_RETRY = 3'd3;
   localparam logic [2:0] REG_RESP_POLL  = 3'd4;

   // sequencer phases, one-hot
   typedef enum logic [19:0] {
      P_IDLE        = 20'h00001,
      P_POWERUP     = 20'h00002,
      P_CMD_DESEL   = 20'h00004,
      P_CMD_READY   = 20'h00008,
      P_CMD_SELFAIL = 20'h00010,
      P_CMD_SEND    = 20'h00020,
      P_CMD_RESP    = 20'h00040,
      P_TRAIL       = 20'h00080,
      P_TOKEN       = 20'h00100,
      P_RDATA       = 20'h00200,
      P_RCRC        = 20'h00400,
      P_WREADY      = 20'h00800,
      P_WTOKEN      = 20'h01000,
      P_WNEED       = 20'h02000,
      P_WDATA       = 20'h04000,
      P_WCRC        = 20'h08000,
      P_WRESP       = 20'h10000,
      P_SREADY      = 20'h20000,
      P_STOPTOK     = 20'h40000,
      P_FINAL       = 20'h80000
   } phase_type;

   // what to do once a command response arrives
   typedef enum logic [4:0] {
      K_CMD0, K_CMD8, K_R7, K_V2_55, K_V2_41, K_CMD58, K_OCR, K_V1_55A, K_V1_41A,
      K_V1_55, K_V1_41, K_CMD1, K_CMD16, K_RD17, K_RD18, K_RD12, K_WR24, K_WR55,
      K_WR23, K_WR25, K_NONE
   } ret_type;

   // one classified word from the front part
   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] sector;
      logic [15:0] block_count;
      logic [7:0]  rx_byte;
      logic [7:0]  data_byte;
   } word_type;

   // configuration limits
   typedef struct packed {
      logic [23:0] ready_wait_limit;
      logic [15:0] token_wait_limit;
      logic [15:0] init_poll_limit;
      logic [7:0]  idle_retry_limit;
      logic [7:0]  response_poll_limit;
   } cfg_type;

   // one result word
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       need_data;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] response_byte;
      logic [2:0] card_kind;
   } result_type;

endpackage

### hdl/sdspi_queue.sv
// sdspi_queue: two-entry word queue between the front and the sequencer
// depends on sdspi_pkg
module sdspi_queue
   import sdspi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  word_type in_word,
   output logic     out_valid,
   input  logic     out_stall,
   output word_type out_word
);

   word_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

### hdl/sdspi_front.sv
// sdspi_front: request intake and configuration registers
// depends on sdspi_pkg
module sdspi_front
   import sdspi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_sector,
   input  logic [15:0] req_block_count,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_data_byte,
   output logic        q_valid,
   input  logic        q_stall,
   output word_type    q_word,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   // intake passes straight into the queue; the queue provides the stall
   assign q_valid   = req_valid;
   assign req_stall = q_stall;
   always_comb begin
      q_word.action      = req_action;
      q_word.sector      = req_sector;
      q_word.block_count = (req_block_count == 16'd0) ? 16'd1 : req_block_count;
      q_word.rx_byte     = req_rx_byte;
      q_word.data_byte   = req_data_byte;
   end

   // register file
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_READY_WAIT: cfg_in.ready_wait_limit    = csr_pwdata[23:0];
            REG_TOKEN_WAIT: cfg_in.token_wait_limit    = csr_pwdata[15:0];
            REG_INIT_POLL:  cfg_in.init_poll_limit     = csr_pwdata[15:0];
            REG_IDLE_RETRY: cfg_in.idle_retry_limit    = csr_pwdata[7:0];
            REG_RESP_POLL:  cfg_in.response_poll_limit = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_READY_WAIT: csr_prdata = {8'd0, cfg_ff.ready_wait_limit};
         REG_TOKEN_WAIT: csr_prdata = {16'd0, cfg_ff.token_wait_limit};
         REG_INIT_POLL:  csr_prdata = {16'd0, cfg_ff.init_poll_limit};
         REG_IDLE_RETRY: csr_prdata = {24'd0, cfg_ff.idle_retry_limit};
         REG_RESP_POLL:  csr_prdata = {24'd0, cfg_ff.response_poll_limit};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_wait_limit    <= 24'hFFFFFF;
         cfg_ff.token_wait_limit    <= 16'hFFFF;
         cfg_ff.init_poll_limit     <= 16'hFFFE;
         cfg_ff.idle_retry_limit    <= 8'd20;
         cfg_ff.response_poll_limit <= 8'h1F;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/sdspi_seq.sv
// sdspi_seq: protocol sequencer, one word per cycle while the result is not stalled, with result output register
// depends on sdspi_pkg
module sdspi_seq
   import sdspi_pkg::*;
#(
   parameter int BLOCK_BYTES = BlockBytes
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_stall,
   input  word_type   q_word,
   input  cfg_type    cfg,
   output logic       res_valid,
   input  logic       res_stall,
   output result_type res
);

   localparam int BW = $clog2(BLOCK_BYTES + 1);

   phase_type   phase_ff, phase_in;
   ret_type     ret_ff, ret_in;
   logic [BW-1:0] bidx_ff, bidx_in;
   logic [23:0] wait_ff, wait_in;
   logic [15:0] retry_ff, retry_in;
   logic [2:0]  card_ff, card_in;
   logic [15:0] left_ff, left_in;
   logic [31:0] arg_ff, arg_in;
   logic [5:0]  cidx_ff, cidx_in;
   logic [31:0] trail_ff, trail_in;
   logic [7:0]  r1_ff, r1_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  ost_ff, ost_in;
   logic        multi_ff, multi_in;
   logic [31:0] baddr_ff, baddr_in;

   result_type  res_ff, res_in;
   logic        rv_ff, rv_in;
   logic        take;

   // output register may be refilled as it drains
   assign q_stall   = rv_ff && res_stall;
   assign take      = q_valid && !q_stall;
   assign res_valid = rv_ff;
   assign res       = res_ff;

   always_comb begin
      logic        fresh, data_tx, rdv, done;
      logic [7:0]  rdb, rx, txb;
      logic [2:0]  st;
      logic [23:0] wnext;
      logic [BW-1:0] bnext;
      logic        launch;
      logic [5:0]  l_idx;
      logic [31:0] l_arg;
      ret_type     l_ret;
      logic        after, rdend, rdok, wrend, wrok;
      logic [31:0] addr;

      phase_in = phase_ff; ret_in = ret_ff; bidx_in = bidx_ff; wait_in = wait_ff;
      retry_in = retry_ff; card_in = card_ff; left_in = left_ff; arg_in = arg_ff;
      cidx_in = cidx_ff; trail_in = trail_ff; r1_in = r1_ff; kind_in = kind_ff;
      ost_in = ost_ff; multi_in = multi_ff; baddr_in = baddr_ff;
      fresh = 1'b0; data_tx = 1'b0; rdv = 1'b0; rdb = 8'd0; done = 1'b0; st = ST_OK;
      rx = q_word.rx_byte;
      wnext = wait_ff + 24'd1;
      bnext = bidx_ff + 1'b1;
      launch = 1'b0; l_idx = 6'd0; l_arg = 32'd0; l_ret = K_NONE;
      after = 1'b0; rdend = 1'b0; rdok = 1'b0; wrend = 1'b0; wrok = 1'b0;
      addr = (card_ff == CK_SDHC) ? q_word.sector : {q_word.sector[22:0], 9'd0};
      txb = 8'hFF;

      if (take) begin
         // new request
         if (q_word.action <= ACT_WRITE && phase_ff == P_IDLE) begin
            kind_in = q_word.action[1:0];
            ost_in  = ST_OK;
            fresh   = 1'b1;
            if (q_word.action == ACT_INIT) begin
               card_in  = CK_NONE;
               bidx_in  = '0;
               phase_in = P_POWERUP;
            end else begin
               left_in  = q_word.block_count;
               multi_in = q_word.block_count > 16'd1;
               baddr_in = addr;
               launch   = 1'b1;
               if (q_word.action == ACT_READ) begin
                  l_idx = multi_in ? 6'd18 : 6'd17;
                  l_arg = addr;
                  l_ret = multi_in ? K_RD18 : K_RD17;
               end else if (!multi_in) begin
                  l_idx = 6'd24; l_arg = addr; l_ret = K_WR24;
               end else if (card_ff != CK_MMC) begin
                  l_idx = 6'd55; l_arg = 32'd0; l_ret = K_WR55;
               end else begin
                  l_idx = 6'd25; l_arg = addr; l_ret = K_WR25;
               end
            end
         // byte exchanged
         end else if (q_word.action == ACT_XCHG && phase_ff != P_IDLE &&
                      phase_ff != P_WNEED) begin
            fresh = 1'b1;
            case (phase_ff)
               P_POWERUP: begin
                  bidx_in = bnext;
                  if (bnext >= BW'(10)) begin
                     retry_in = '0; launch = 1'b1; l_ret = K_CMD0;
                  end
               end
               P_CMD_DESEL: begin
                  wait_in = '0; phase_in = P_CMD_READY;
               end
               P_CMD_READY: begin
                  if (rx == 8'hFF) begin
                     bidx_in = '0; phase_in = P_CMD_SEND;
                  end else begin
                     wait_in = wnext;
                     if (wnext >= cfg.ready_wait_limit) phase_in = P_CMD_SELFAIL;
                  end
               end
               P_CMD_SELFAIL: begin
                  r1_in = 8'hFF; after = 1'b1;
               end
               P_CMD_SEND: begin
                  bidx_in = bnext;
                  if (bnext >= ((cidx_ff == 6'd12) ? BW'(7) : BW'(6))) begin
                     bidx_in = '0; phase_in = P_CMD_RESP;
                  end
               end
               P_CMD_RESP: begin
                  if (rx[7] && bidx_ff < BW'(cfg.response_poll_limit)) bidx_in = bnext;
                  else begin
                     r1_in = rx; after = 1'b1;
                  end
               end
               P_TRAIL: begin
                  trail_in = {trail_ff[23:0], rx};
                  bidx_in  = bnext;
                  if (bnext >= BW'(4)) after = 1'b1;
               end
               P_TOKEN: begin
                  if (rx == 8'hFE) begin
                     bidx_in = '0; phase_in = P_RDATA;
                  end else begin
                     wait_in = wnext;
                     if (wnext >= {8'd0, cfg.token_wait_limit}) begin
                        ost_in = ST_TOKTO; rdend = 1'b1;
                     end
                  end
               end
               P_RDATA: begin
                  rdv = 1'b1; rdb = rx; bidx_in = bnext;
                  if (bnext >= BW'(BLOCK_BYTES)) begin
                     bidx_in = '0; phase_in = P_RCRC;
                  end
               end
               P_RCRC: begin
                  bidx_in = bnext;
                  if (bnext >= BW'(2)) begin
                     rdend = 1'b1; rdok = 1'b1;
                  end
               end
               P_WREADY: begin
                  if (rx == 8'hFF) phase_in = P_WTOKEN;
                  else begin
                     wait_in = wnext;
                     if (wnext >= cfg.ready_wait_limit) begin
                        ost_in = ST_NRDY; wrend = 1'b1;
                     end
                  end
               end
               P_WTOKEN: begin
                  bidx_in = '0; phase_in = P_WNEED;
               end
               P_WDATA: begin
                  bidx_in = bnext;
                  if (bnext >= BW'(BLOCK_BYTES)) begin
                     bidx_in = '0; phase_in = P_WCRC;
                  end else phase_in = P_WNEED;
               end
               P_WCRC: begin
                  bidx_in = bnext;
                  if (bnext >= BW'(2)) phase_in = P_WRESP;
               end
               P_WRESP: begin
                  wrend = 1'b1;
                  if (rx[4:0] != 5'h05) ost_in = ST_WREJ;
                  else wrok = 1'b1;
               end
               P_SREADY: begin
                  if (rx == 8'hFF) phase_in = P_STOPTOK;
                  else begin
                     wait_in = wnext;
                     if (wnext >= cfg.ready_wait_limit) begin
                        if (ost_ff == ST_OK) ost_in = ST_NRDY;
                        phase_in = P_FINAL;
                     end
                  end
               end
               P_STOPTOK: phase_in = P_FINAL;
               P_FINAL: begin
                  phase_in = P_IDLE; done = 1'b1;
                  if (kind_ff == 2'd0)
                     st = (card_ff == CK_NONE) ? ST_NOCARD :
                          ((card_ff == CK_ERR) ? ST_BADCARD : ST_OK);
                  else st = ost_ff;
               end
               default: ;
            endcase
         // write payload byte
         end else if (q_word.action == ACT_DATA && phase_ff == P_WNEED) begin
            phase_in = P_WDATA; fresh = 1'b1; data_tx = 1'b1;
         end
      end

      // response dispatch
      if (after) begin
         case (ret_ff)
            K_CMD0: begin
               if (r1_in == 8'h01) begin
                  launch = 1'b1; l_idx = 6'd8; l_arg = 32'h1AA; l_ret = K_CMD8;
               end else if ({8'd0, retry_ff} < {8'd0, cfg.idle_retry_limit}) begin
                  retry_in = retry_ff + 16'd1; launch = 1'b1; l_ret = K_CMD0;
               end else phase_in = P_FINAL;
            end
            K_CMD8: begin
               if (r1_in == 8'h01) begin
                  trail_in = '0; bidx_in = '0; ret_in = K_R7; phase_in = P_TRAIL;
               end else begin
                  launch = 1'b1; l_idx = 6'd55; l_ret = K_V1_55A;
               end
            end
            K_R7: begin
               if (trail_in[15:0] == 16'h01AA) begin
                  retry_in = '0; launch = 1'b1; l_idx = 6'd55; l_ret = K_V2_55;
               end else phase_in = P_FINAL;
            end
            K_V2_55: begin
               launch = 1'b1; l_idx = 6'd41; l_arg = 32'h40000000; l_ret = K_V2_41;
            end
            K_V2_41: begin
               if (r1_in == 8'd0) begin
                  launch = 1'b1; l_idx = 6'd58; l_ret = K_CMD58;
               end else if (retry_ff < cfg.init_poll_limit) begin
                  retry_in = retry_ff + 16'd1; launch = 1'b1; l_idx = 6'd55; l_ret = K_V2_55;
               end else phase_in = P_FINAL;
            end
            K_CMD58: begin
               if (r1_in == 8'd0) begin
                  trail_in = '0; bidx_in = '0; ret_in = K_OCR; phase_in = P_TRAIL;
               end else phase_in = P_FINAL;
            end
            K_OCR: begin
               card_in = trail_in[30] ? CK_SDHC : CK_SDV2; phase_in = P_FINAL;
            end
            K_V1_55A: begin
               launch = 1'b1; l_idx = 6'd41; l_ret = K_V1_41A;
            end
            K_V1_41A: begin
               retry_in = '0; launch = 1'b1;
               if (r1_in <= 8'd1) begin
                  card_in = CK_SDV1; l_idx = 6'd55; l_ret = K_V1_55;
               end else begin
                  card_in = CK_MMC; l_idx = 6'd1; l_ret = K_CMD1;
               end
            end
            K_V1_55: begin
               launch = 1'b1; l_idx = 6'd41; l_ret = K_V1_41;
            end
            K_V1_41, K_CMD1: begin
               if (r1_in == 8'd0) begin
                  launch = 1'b1; l_idx = 6'd16; l_arg = 32'(BLOCK_BYTES); l_ret = K_CMD16;
               end else if (retry_ff < cfg.init_poll_limit) begin
                  retry_in = retry_ff + 16'd1; launch = 1'b1;
                  if (ret_ff == K_CMD1) begin
                     l_idx = 6'd1; l_ret = K_CMD1;
                  end else begin
                     l_idx = 6'd55; l_ret = K_V1_55;
                  end
               end else begin
                  card_in = CK_ERR; phase_in = P_FINAL;
               end
            end
            K_CMD16: begin
               if (r1_in != 8'd0) card_in = CK_ERR;
               phase_in = P_FINAL;
            end
            K_RD17, K_RD18: begin
               if (r1_in == 8'd0) begin
                  wait_in = '0; phase_in = P_TOKEN;
               end else begin
                  ost_in = ST_CMDERR; phase_in = P_FINAL;
               end
            end
            K_WR55: begin
               launch = 1'b1; l_idx = 6'd23; l_arg = {16'd0, left_ff}; l_ret = K_WR23;
            end
            K_WR23: begin
               launch = 1'b1; l_idx = 6'd25; l_arg = baddr_ff; l_ret = K_WR25;
            end
            K_WR24, K_WR25: begin
               if (r1_in == 8'd0) begin
                  wait_in = '0; phase_in = P_WREADY;
               end else begin
                  ost_in = ST_CMDERR; phase_in = P_FINAL;
               end
            end
            default: phase_in = P_FINAL;
         endcase
      end

      // end of a read block
      if (rdend) begin
         if (rdok && multi_ff && left_ff > 16'd1) begin
            left_in = left_ff - 16'd1; wait_in = '0; phase_in = P_TOKEN;
         end else if (multi_ff) begin
            launch = 1'b1; l_idx = 6'd12; l_ret = K_RD12;
         end else phase_in = P_FINAL;
      end

      // end of a write block
      if (wrend) begin
         if (!multi_ff) phase_in = P_FINAL;
         else begin
            wait_in = '0;
            if (wrok && left_ff > 16'd1) begin
               left_in = left_ff - 16'd1; phase_in = P_WREADY;
            end else phase_in = P_SREADY;
         end
      end

      // command launch
      if (launch) begin
         cidx_in = l_idx; arg_in = l_arg; ret_in = l_ret; phase_in = P_CMD_DESEL;
      end

      // next transmit byte
      case (phase_in)
         P_CMD_SEND: begin
            case (bidx_in)
               BW'(0): txb = {2'b01, cidx_in};
               BW'(1): txb = arg_in[31:24];
               BW'(2): txb = arg_in[23:16];
               BW'(3): txb = arg_in[15:8];
               BW'(4): txb = arg_in[7:0];
               BW'(5): txb = (cidx_in == 6'd0) ? 8'h95 :
                             ((cidx_in == 6'd8) ? 8'h87 : 8'h01);
               default: txb = 8'hFF;
            endcase
         end
         P_WTOKEN:  txb = multi_in ? 8'hFC : 8'hFE;
         P_STOPTOK: txb = 8'hFD;
         default:   txb = 8'hFF;
      endcase
      if (data_tx) txb = q_word.data_byte;

      res_in.tx_valid = fresh && phase_in != P_IDLE && phase_in != P_WNEED;
      res_in.tx_byte  = res_in.tx_valid ? txb : 8'd0;
      res_in.chip_select = (phase_in == P_IDLE || phase_in == P_POWERUP ||
                            phase_in == P_CMD_DESEL || phase_in == P_CMD_SELFAIL ||
                            phase_in == P_FINAL);
      res_in.read_valid    = rdv;
      res_in.read_byte     = rdb;
      res_in.need_data     = (phase_in == P_WNEED);
      res_in.done_res      = done;
      res_in.status        = st;
      res_in.response_byte = r1_in;
      res_in.card_kind     = card_in;
      rv_in = take ? 1'b1 : (rv_ff && res_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE; ret_ff <= K_NONE; bidx_ff <= '0; wait_ff <= '0;
         retry_ff <= '0; card_ff <= CK_NONE; left_ff <= '0; arg_ff <= '0;
         cidx_ff <= '0; trail_ff <= '0; r1_ff <= 8'hFF; kind_ff <= '0;
         ost_ff <= ST_OK; multi_ff <= 1'b0; baddr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; ret_ff <= ret_in; bidx_ff <= bidx_in; wait_ff <= wait_in;
         retry_ff <= retry_in; card_ff <= card_in; left_ff <= left_in; arg_ff <= arg_in;
         cidx_ff <= cidx_in; trail_ff <= trail_in; r1_ff <= r1_in; kind_ff <= kind_in;
         ost_ff <= ost_in; multi_ff <= multi_in; baddr_ff <= baddr_in; rv_ff <= rv_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (take) res_ff <= res_in;
   end

endmodule

### hdl/sd_spi_mode_host_engine.sv
// channel  | direction | handshake
// req_     | in        | req_valid / req_stall, word = action plus operands
// rsp_     | out       | rsp_valid / rsp_stall, word = one result per request word
// csr_     | in/out    | apb-style, registers at 4*index
// one word per cycle sustained while rsp_stall is low; a word passes a two-entry queue
// and the sequencer, then waits in the result register
// synchronous active-high reset restores default limits and idle state
// a stalled result backs up the queue, then req_stall rises
// top level: depends on sdspi_pkg, sdspi_front, sdspi_queue, sdspi_seq
module sd_spi_mode_host_engine
   import sdspi_pkg::*;
#(
   parameter int BLOCK_BYTES = BlockBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_sector,
   input  logic [15:0] req_block_count,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_chip_select,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_need_data,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_response_byte,
   output logic [2:0]  rsp_card_kind,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic       f_valid, f_stall, s_valid, s_stall;
   word_type   f_word, s_word;
   cfg_type    cfg;
   result_type res;

   // intake and registers
   sdspi_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_sector,
      .req_block_count, .req_rx_byte, .req_data_byte,
      .q_valid(f_valid), .q_stall(f_stall), .q_word(f_word),
      .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata),
      .csr_pready(pready), .cfg(cfg)
   );

   // decoupling queue
   sdspi_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_word(f_word),
      .out_valid(s_valid), .out_stall(s_stall), .out_word(s_word)
   );

   // sequencer
   sdspi_seq #(.BLOCK_BYTES(BLOCK_BYTES)) u_seq (
      .clock, .reset, .q_valid(s_valid), .q_stall(s_stall), .q_word(s_word),
      .cfg(cfg), .res_valid(rsp_valid), .res_stall(rsp_stall), .res(res)
   );

   assign rsp_tx_valid      = res.tx_valid;
   assign rsp_tx_byte       = res.tx_byte;
   assign rsp_chip_select   = res.chip_select;
   assign rsp_read_valid    = res.read_valid;
   assign rsp_read_byte     = res.read_byte;
   assign rsp_need_data     = res.need_data;
   assign rsp_done_res      = res.done_res;
   assign rsp_status        = res.status;
   assign rsp_response_byte = res.response_byte;
   assign rsp_card_kind     = res.card_kind;

   // status only reported with done
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == ST_OK)
      else $error("status without done");

   // read payload bytes are never delivered with a released select
   a_read_sel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> !rsp_chip_select)
      else $error("read data while deselected");

   // waiting for data means no exchange is launched
   a_need_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_need_data |-> !rsp_tx_valid)
      else $error("exchange while waiting for data");

endmodule
